>>> src/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/cdt_pkg.sv
// Constants, widths and calendar helpers for the timestamp to civil date converter.
package cdt_pkg;

   localparam int TS_W     = 32;
   localparam int OPER_W   = 32;
   localparam int DAYS_W   = 16;
   localparam int CNT_W    = 4;
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int MOD100_W = 7;
   localparam int MOD400_W = 9;

   localparam int DAY_SECS   = 86400;
   localparam int HOUR_SECS  = 3600;
   localparam int MIN_SECS   = 60;
   localparam int EPOCH_YEAR = 1970;
   localparam int LEAP_DAYS  = 366;
   localparam int YEAR_DAYS  = 365;
   localparam int FEB_LEAP   = 29;
   localparam int FEB_MONTH  = 2;

   // Division step counts: quotient bits of each stage.
   localparam int DAY_Q_BITS  = 16;
   localparam int HOUR_Q_BITS = 5;
   localparam int MIN_Q_BITS  = 6;

   localparam logic [DAY_W-1:0] MONTH_LEN [0:12] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [OPER_W-1:0] diff;
      logic              ge;
   } sub_res_type;

   function automatic logic is_leap(input logic [1:0]          year_lo,
                                    input logic [MOD100_W-1:0] mod100,
                                    input logic [MOD400_W-1:0] mod400);
      is_leap = (year_lo == 2'd0) && ((mod100 != '0) || (mod400 == '0));
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic               leap);
      logic [DAY_W-1:0] len;
      len = (month <= MONTH_W'(12)) ? MONTH_LEN[month] : '0;
      if (leap && (month == MONTH_W'(FEB_MONTH))) begin
         len = DAY_W'(FEB_LEAP);
      end
      month_length = len;
   endfunction

endpackage

>>> src/cdt_sub_unit.sv
// Shared subtract and compare unit: a - b and a >= b.
module cdt_sub_unit (
   input  logic [cdt_pkg::OPER_W-1:0] oper_a,
   input  logic [cdt_pkg::OPER_W-1:0] oper_b,
   output cdt_pkg::sub_res_type       res
);
   import cdt_pkg::*;

   logic [OPER_W:0] diff_full;

   assign diff_full = {1'b0, oper_a} - {1'b0, oper_b};
   assign res.diff  = diff_full[OPER_W-1:0];
   assign res.ge    = ~diff_full[OPER_W];

endmodule

>>> src/unix_time_to_civil_date_core.sv
// Top level: sequencer that converts a seconds count into calendar date and time.
`include "assert_macros.svh"

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into year, month,
// day, hour, minute and second. A transaction is taken when start is high and
// busy is low; the result appears for one cycle with rsp_strobe and cannot be
// held off. Every subtraction and compare uses one shared subtract/compare
// unit: restoring division by 86400 for 16 day bits, by 3600 for 5 hour bits and
// by 60 for 6 minute bits, then one step per year elapsed since 1970 plus one,
// then one step per month up to the result month. Busy stays high from acceptance
// until the result is given, so no new transaction is taken before then.
// A zero timestamp is rejected at once: all-zero result on the next cycle,
// busy never rises.
module unix_time_to_civil_date_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cdt_pkg::TS_W-1:0]      req_timestamp,
   output logic                          rsp_strobe,
   output logic                          rsp_valid_res,
   output logic [cdt_pkg::YEAR_W-1:0]    rsp_year,
   output logic [cdt_pkg::MONTH_W-1:0]   rsp_month,
   output logic [cdt_pkg::DAY_W-1:0]     rsp_day,
   output logic [cdt_pkg::HOUR_W-1:0]    rsp_hour,
   output logic [cdt_pkg::MINUTE_W-1:0]  rsp_minute,
   output logic [cdt_pkg::SECOND_W-1:0]  rsp_second
);
   import cdt_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DAY_DIV  = 6'b000010,
      ST_HOUR_DIV = 6'b000100,
      ST_MIN_DIV  = 6'b001000,
      ST_YEAR     = 6'b010000,
      ST_MONTH    = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [OPER_W-1:0]     rem_ff, rem_in;
   logic [DAYS_W-1:0]     days_ff, days_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [HOUR_W-1:0]     hour_ff, hour_in;
   logic [MINUTE_W-1:0]   minute_ff, minute_in;
   logic [YEAR_W-1:0]     year_ff, year_in;
   logic [MOD100_W-1:0]   mod100_ff, mod100_in;
   logic [MOD400_W-1:0]   mod400_ff, mod400_in;
   logic [MONTH_W-1:0]    month_ff, month_in;

   logic                  strobe_ff, strobe_in;
   logic                  out_valid_ff, out_valid_in;
   logic [YEAR_W-1:0]     out_year_ff, out_year_in;
   logic [MONTH_W-1:0]    out_month_ff, out_month_in;
   logic [DAY_W-1:0]      out_day_ff, out_day_in;
   logic [HOUR_W-1:0]     out_hour_ff, out_hour_in;
   logic [MINUTE_W-1:0]   out_minute_ff, out_minute_in;
   logic [SECOND_W-1:0]   out_second_ff, out_second_in;

   logic [OPER_W-1:0]     oper_a, oper_b;
   sub_res_type           sub_res;
   logic                  leap;
   logic                  accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign leap   = is_leap(year_ff[1:0], mod100_ff, mod400_ff);

   cdt_sub_unit u_sub (
      .oper_a (oper_a),
      .oper_b (oper_b),
      .res    (sub_res)
   );

   // Operand select for the shared unit; divisors are pre-shifted by the bit index.
   always_comb begin
      oper_a = rem_ff;
      oper_b = '0;
      case (state_ff)
         ST_DAY_DIV: begin
            oper_b = OPER_W'(DAY_SECS) << cnt_ff;
         end
         ST_HOUR_DIV: begin
            oper_b = OPER_W'(HOUR_SECS) << cnt_ff;
         end
         ST_MIN_DIV: begin
            oper_b = OPER_W'(MIN_SECS) << cnt_ff;
         end
         ST_YEAR: begin
            oper_a = OPER_W'(days_ff);
            oper_b = leap ? OPER_W'(LEAP_DAYS) : OPER_W'(YEAR_DAYS);
         end
         ST_MONTH: begin
            oper_a = OPER_W'(days_ff);
            oper_b = OPER_W'(month_length(month_ff, leap));
         end
         default: begin
            oper_a = rem_ff;
            oper_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      days_in       = days_ff;
      cnt_in        = cnt_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      year_in       = year_ff;
      mod100_in     = mod100_ff;
      mod400_in     = mod400_ff;
      month_in      = month_ff;
      strobe_in     = 1'b0;
      out_valid_in  = out_valid_ff;
      out_year_in   = out_year_ff;
      out_month_in  = out_month_ff;
      out_day_in    = out_day_ff;
      out_hour_in   = out_hour_ff;
      out_minute_in = out_minute_ff;
      out_second_in = out_second_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_timestamp == '0) begin
                  strobe_in     = 1'b1;
                  out_valid_in  = 1'b0;
                  out_year_in   = '0;
                  out_month_in  = '0;
                  out_day_in    = '0;
                  out_hour_in   = '0;
                  out_minute_in = '0;
                  out_second_in = '0;
               end else begin
                  rem_in   = OPER_W'(req_timestamp);
                  cnt_in   = CNT_W'(DAY_Q_BITS - 1);
                  state_in = ST_DAY_DIV;
               end
            end
         end
         ST_DAY_DIV: begin
            if (sub_res.ge) begin
               rem_in = sub_res.diff;
            end
            days_in = {days_ff[DAYS_W-2:0], sub_res.ge};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               hour_in  = '0;
               cnt_in   = CNT_W'(HOUR_Q_BITS - 1);
               state_in = ST_HOUR_DIV;
            end
         end
         ST_HOUR_DIV: begin
            if (sub_res.ge) begin
               rem_in = sub_res.diff;
            end
            hour_in = {hour_ff[HOUR_W-2:0], sub_res.ge};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               minute_in = '0;
               cnt_in    = CNT_W'(MIN_Q_BITS - 1);
               state_in  = ST_MIN_DIV;
            end
         end
         ST_MIN_DIV: begin
            if (sub_res.ge) begin
               rem_in = sub_res.diff;
            end
            minute_in = {minute_ff[MINUTE_W-2:0], sub_res.ge};
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               year_in   = YEAR_W'(EPOCH_YEAR);
               mod100_in = MOD100_W'(EPOCH_YEAR % 100);
               mod400_in = MOD400_W'(EPOCH_YEAR % 400);
               state_in  = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (sub_res.ge) begin
               days_in   = sub_res.diff[DAYS_W-1:0];
               year_in   = year_ff + 1'b1;
               mod100_in = (mod100_ff == MOD100_W'(99)) ? '0 : mod100_ff + 1'b1;
               mod400_in = (mod400_ff == MOD400_W'(399)) ? '0 : mod400_ff + 1'b1;
            end else begin
               month_in = MONTH_W'(1);
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (sub_res.ge) begin
               days_in  = sub_res.diff[DAYS_W-1:0];
               month_in = month_ff + 1'b1;
            end else begin
               strobe_in     = 1'b1;
               out_valid_in  = 1'b1;
               out_year_in   = year_ff;
               out_month_in  = month_ff;
               out_day_in    = DAY_W'(days_ff) + 1'b1;
               out_hour_in   = hour_ff;
               out_minute_in = minute_ff;
               out_second_in = rem_ff[SECOND_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      days_ff       <= days_in;
      cnt_ff        <= cnt_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      year_ff       <= year_in;
      mod100_ff     <= mod100_in;
      mod400_ff     <= mod400_in;
      month_ff      <= month_in;
      out_valid_ff  <= out_valid_in;
      out_year_ff   <= out_year_in;
      out_month_ff  <= out_month_in;
      out_day_ff    <= out_day_in;
      out_hour_ff   <= out_hour_in;
      out_minute_ff <= out_minute_in;
      out_second_ff <= out_second_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_valid_res = out_valid_ff;
   assign rsp_year      = out_year_ff;
   assign rsp_month     = out_month_ff;
   assign rsp_day       = out_day_ff;
   assign rsp_hour      = out_hour_ff;
   assign rsp_minute    = out_minute_ff;
   assign rsp_second    = out_second_ff;

   `ASSERT_NEXT(a_busy_after_start, clock, reset,
                accept && (req_timestamp != '0), busy,
                "nonzero transaction did not raise busy")
   `ASSERT_NEXT(a_zero_reject, clock, reset,
                accept && (req_timestamp == '0), rsp_strobe && !rsp_valid_res,
                "zero timestamp not rejected on next cycle")
   `ASSERT_HOLDS(a_strobe_idle, clock, reset, rsp_strobe |-> !busy,
                 "result strobe while busy")
   `ASSERT_HOLDS(a_date_range, clock, reset,
                 (rsp_strobe && rsp_valid_res) |->
                    ((rsp_month != '0) && (rsp_month <= MONTH_W'(12)) && (rsp_day != '0)),
                 "converted date out of range")

endmodule
